FILE: rtl/urir_pkg.sv
// Shared constants for the uniform range draw block.
package urir_pkg;

  localparam int unsigned MagW     = 81;
  localparam int unsigned Grid     = 46;
  localparam int unsigned KeepBits = 53;
  localparam int unsigned RndLsb   = MagW - 1 - KeepBits;
  localparam int unsigned NormTop  = MagW - 2;

  localparam logic [31:0] LcgMul    = 32'd69069;
  localparam int unsigned LcgSteps  = 17;
  localparam logic [31:0] ZeroSeed  = 32'd259341593;
  localparam int unsigned MulSteps  = 47;
  localparam int unsigned DivSteps  = 112;
  localparam int unsigned DivBits   = 80;
  localparam logic [32:0] Divisor   = 33'h0_FFFF_FFFF;

  localparam logic [31:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [31:0] IntMin = 32'h8000_0000;

  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_TOP  = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  localparam logic [2:0] PH_P = 3'd0;
  localparam logic [2:0] PH_U = 3'd1;
  localparam logic [2:0] PH_R = 3'd2;
  localparam logic [2:0] PH_X = 3'd3;
  localparam logic [2:0] PH_Q = 3'd4;
  localparam logic [2:0] PH_F = 3'd5;

endpackage

FILE: rtl/uniform_random_in_range.sv
// Uniform draw over a signed 32-bit range from a 32-bit congruential seed.
//
// Input channel (in_valid_i / in_stall_o): one beat is a request. op_i 1
// loads seed_value_i into the seed; op_i 0 draws a value in the inclusive
// range range_start_i .. range_end_i. Output channel (out_valid_o /
// out_stall_i): one beat per request with value_o and the seed after it.
// A seed load or a range of at most one value goes to the output state,
// and its beat is registered once the output register is free; the next
// request can be taken once that beat is in the output register. A draw
// runs a bit-serial seed multiply, a shift-add range multiply and two to
// five roundings, each with a normalize and a denormalize shift by up to
// 80 bit positions; the full signed range adds a restoring division.
// One request is in work at a time; in_stall_o is high while it is.
// A finished beat waits in the output register while the receiver
// stalls, and the next request may already be taken. Reset clears the
// seed to zero and empties the output register.
module uniform_random_in_range (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [31:0] seed_value_i,
  input  logic signed [31:0] range_start_i,
  input  logic signed [31:0] range_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic signed [31:0] seed_out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LCG   = 4'd1;
  localparam logic [3:0] S_FRAC  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_RND   = 4'd5;
  localparam logic [3:0] S_DEN   = 4'd6;
  localparam logic [3:0] S_SIGN  = 4'd7;
  localparam logic [3:0] S_ADDK  = 4'd8;
  localparam logic [3:0] S_ABS   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FLOOR = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam int unsigned MW = urir_pkg::MagW;
  localparam int unsigned GR = urir_pkg::Grid;
  localparam int unsigned HW = MW - GR;

  logic [3:0]    state_q;
  logic [2:0]    phase_q;
  logic [1:0]    mode_q;
  logic [6:0]    cnt_q;
  logic [6:0]    sh_q;
  logic [31:0]   seed_q;
  logic [31:0]   acc_q;
  logic [31:0]   mcand_q;
  logic [32:0]   d_q;
  logic [31:0]   a_q;
  logic [HW-1:0] k_q;
  logic [MW-1:0] mag_q;
  logic          sgn_q;
  logic          sticky_q;
  logic [31:0]   rem_q;
  logic [31:0]   start_q;
  logic [31:0]   end_q;
  logic [31:0]   res_q;
  logic          out_valid_q;
  logic [31:0]   value_q;
  logic [31:0]   seed_out_q;

  logic          in_acc;
  logic          out_free;
  logic [1:0]    mode_d;
  logic [31:0]   seed_eff;
  logic [31:0]   acc_next;
  logic [22:0]   frac_m;
  logic [46:0]   frac_f;
  logic [33:0]   hi_sum;
  logic [52:0]   rnd_q;
  logic          rnd_up;
  logic [53:0]   rnd_sum;
  logic [MW-1:0] mag_neg;
  logic [32:0]   div_tr;
  logic          div_ge;
  logic [32:0]   div_diff;
  logic [31:0]   rem_next;
  logic          div_bit;
  logic signed [35:0] fl;
  logic signed [35:0] lo36;
  logic signed [35:0] hi36;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign seed_out_o  = seed_out_q;

  always_comb begin
    if (range_end_i != urir_pkg::IntMax) begin
      mode_d = urir_pkg::MODE_LOW;
    end else if (range_start_i != urir_pkg::IntMin) begin
      mode_d = urir_pkg::MODE_TOP;
    end else begin
      mode_d = urir_pkg::MODE_FULL;
    end
  end

  assign seed_eff = (seed_q == 32'd0) ? urir_pkg::ZeroSeed : seed_q;
  assign acc_next = acc_q + (urir_pkg::LcgMul[cnt_q[4:0]] ? mcand_q : 32'd0);
  assign frac_m   = seed_q[31:9];
  assign frac_f   = {({1'b0, frac_m} + 24'd1), 23'd0} + {24'd0, frac_m};
  assign hi_sum   = mag_q[MW-1:47] + (mag_q[0] ? {1'b0, d_q} : 34'd0);

  assign rnd_q   = mag_q[MW-2:urir_pkg::RndLsb];
  assign rnd_up  = mag_q[urir_pkg::RndLsb-1]
                   && ((|mag_q[urir_pkg::RndLsb-2:0]) || sticky_q || rnd_q[0]);
  assign rnd_sum = {1'b0, rnd_q} + {53'd0, rnd_up};
  assign mag_neg = ~mag_q + {{(MW-1){1'b0}}, 1'b1};

  assign div_bit  = (cnt_q < 7'(urir_pkg::DivBits)) ? mag_q[urir_pkg::DivBits-1] : 1'b0;
  assign div_tr   = {rem_q, div_bit};
  assign div_ge   = (div_tr >= urir_pkg::Divisor);
  assign div_diff = div_tr - urir_pkg::Divisor;
  assign rem_next = div_ge ? div_diff[31:0] : div_tr[31:0];

  always_comb begin
    fl   = sgn_q ? ~{1'b0, mag_q[MW-1:GR]} : {1'b0, mag_q[MW-1:GR]};
    lo36 = 36'($signed(start_q));
    hi36 = 36'($signed(end_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= 32'd0;
      out_valid_q <= 1'b0;
      phase_q     <= urir_pkg::PH_P;
      mode_q      <= urir_pkg::MODE_LOW;
      cnt_q       <= 7'd0;
      sh_q        <= 7'd0;
      sgn_q       <= 1'b0;
      sticky_q    <= 1'b0;
    end else begin
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            start_q <= range_start_i;
            end_q   <= range_end_i;
            mode_q  <= mode_d;
            if (op_i) begin
              seed_q  <= seed_value_i;
              res_q   <= 32'd0;
              state_q <= S_OUT;
            end else if (range_start_i >= range_end_i) begin
              res_q   <= range_start_i;
              state_q <= S_OUT;
            end else begin
              d_q      <= {range_end_i[31], range_end_i} - {range_start_i[31], range_start_i}
                          + ((mode_d == urir_pkg::MODE_FULL) ? 33'd0 : 33'd1);
              a_q      <= range_start_i - ((mode_d == urir_pkg::MODE_TOP) ? 32'd1 : 32'd0);
              acc_q    <= 32'd1;
              mcand_q  <= seed_eff;
              cnt_q    <= 7'd0;
              sticky_q <= 1'b0;
              sgn_q    <= 1'b0;
              state_q  <= S_LCG;
            end
          end
        end
        S_LCG: begin
          acc_q   <= acc_next;
          mcand_q <= {mcand_q[30:0], 1'b0};
          cnt_q   <= cnt_q + 7'd1;
          if (cnt_q == 7'(urir_pkg::LcgSteps - 1)) begin
            seed_q  <= acc_next;
            state_q <= S_FRAC;
          end
        end
        S_FRAC: begin
          mag_q   <= {34'd0, frac_f};
          cnt_q   <= 7'd0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          mag_q <= {1'b0, hi_sum, mag_q[46:1]};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(urir_pkg::MulSteps - 1)) begin
            phase_q <= urir_pkg::PH_P;
            sh_q    <= 7'd0;
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (mag_q[urir_pkg::NormTop] || (sh_q == 7'(urir_pkg::NormTop + 1))) begin
            state_q <= S_RND;
          end else begin
            mag_q <= {mag_q[MW-2:0], 1'b0};
            sh_q  <= sh_q + 7'd1;
          end
        end
        S_RND: begin
          mag_q   <= {rnd_sum, {urir_pkg::RndLsb{1'b0}}};
          state_q <= S_DEN;
        end
        S_DEN: begin
          if (sh_q != 7'd0) begin
            mag_q <= {1'b0, mag_q[MW-1:1]};
            sh_q  <= sh_q - 7'd1;
          end else begin
            case (phase_q)
              urir_pkg::PH_P: begin
                k_q     <= HW'($signed(a_q));
                phase_q <= urir_pkg::PH_U;
                state_q <= S_SIGN;
              end
              urir_pkg::PH_U: begin
                case (mode_q)
                  urir_pkg::MODE_LOW: begin
                    state_q <= S_FLOOR;
                  end
                  urir_pkg::MODE_TOP: begin
                    k_q     <= HW'(1);
                    phase_q <= urir_pkg::PH_R;
                    state_q <= S_SIGN;
                  end
                  default: begin
                    k_q     <= HW'({1'b0, urir_pkg::IntMin});
                    phase_q <= urir_pkg::PH_X;
                    state_q <= S_SIGN;
                  end
                endcase
              end
              urir_pkg::PH_X: begin
                cnt_q   <= 7'd0;
                rem_q   <= 32'd0;
                state_q <= S_DIV;
              end
              urir_pkg::PH_Q: begin
                k_q     <= HW'($signed(urir_pkg::IntMin));
                phase_q <= urir_pkg::PH_F;
                state_q <= S_SIGN;
              end
              default: begin
                state_q <= S_FLOOR;
              end
            endcase
          end
        end
        S_SIGN: begin
          if (sgn_q) begin
            mag_q <= mag_neg;
          end
          state_q <= S_ADDK;
        end
        S_ADDK: begin
          mag_q[MW-1:GR] <= mag_q[MW-1:GR] + k_q;
          state_q        <= S_ABS;
        end
        S_ABS: begin
          sgn_q    <= mag_q[MW-1];
          if (mag_q[MW-1]) begin
            mag_q <= mag_neg;
          end
          sticky_q <= 1'b0;
          sh_q     <= 7'd0;
          state_q  <= S_NORM;
        end
        S_DIV: begin
          mag_q <= {1'b0, mag_q[urir_pkg::DivBits-2:0], div_ge};
          rem_q <= rem_next;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(urir_pkg::DivSteps - 1)) begin
            sticky_q <= (rem_next != 32'd0);
            sgn_q    <= 1'b0;
            sh_q     <= 7'd0;
            phase_q  <= urir_pkg::PH_Q;
            state_q  <= S_NORM;
          end
        end
        S_FLOOR: begin
          if (fl < lo36) begin
            res_q <= start_q;
          end else if (fl > hi36) begin
            res_q <= end_q;
          end else begin
            res_q <= fl[31:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            value_q     <= res_q;
            seed_out_q  <= seed_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/uniform_random_in_range_test.sv
// Self-checking testbench for the uniform range draw block with a bit-exact draw predictor.
module uniform_random_in_range_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 3_000_000;
  localparam int RandomItems = 800;
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef logic [127:0] fix_t;
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] seed;
  } draw_beat_t;

  class draw_scoreboard;
    logic [31:0] seed;
    draw_beat_t  awaited[$];
    int          errors;
    int          beats;

    function new();
      seed = '0;
      errors = 0;
      beats = 0;
    endfunction

    function int bit_len(fix_t v);
      for (int i = 127; i >= 0; i--) if (v[i]) return i + 1;
      return 0;
    endfunction

    function fix_t round53(fix_t v, bit sticky);
      int   len;
      int   k;
      fix_t q;
      fix_t low;
      fix_t half;
      len = bit_len(v);
      if (len <= urir_pkg::KeepBits) return v;
      k = len - urir_pkg::KeepBits;
      q = v >> k;
      low = v - (q << k);
      half = fix_t'(1) << (k - 1);
      if (low > half || (low == half && (sticky || q[0]))) q = q + 1;
      return q << k;
    endfunction

    function fix_t round_signed53(fix_t v);
      fix_t m;
      m = round53(v[127] ? -v : v, 1'b0);
      return v[127] ? -m : m;
    endfunction

    function fix_t to_grid(longint x);
      fix_t g;
      g = {{64{x[63]}}, x};
      return g << urir_pkg::Grid;
    endfunction

    function longint floor_of(fix_t v);
      fix_t m;
      if (v[127]) begin
        m = (-v) >> urir_pkg::Grid;
        return -longint'(m[63:0]) - 1;
      end
      m = v >> urir_pkg::Grid;
      return longint'(m[63:0]);
    endfunction

    function fix_t scaled_draw(longint a, longint b);
      logic [31:0] m;
      logic [63:0] f;
      fix_t        p;
      if (seed == 0) seed = urir_pkg::ZeroSeed;
      seed = seed * urir_pkg::LcgMul + 1;
      m = seed >> 9;
      f = (64'(m + 1) << 23) + 64'(m);
      p = round53(fix_t'(b - a) * fix_t'(f), 1'b0);
      return round_signed53(to_grid(a) + p);
    endfunction

    function void note_request(logic op, logic [31:0] sv, logic [31:0] rs, logic [31:0] re);
      longint     lo;
      longint     hi;
      longint     i;
      fix_t       x;
      fix_t       q;
      fix_t       n;
      bit         sticky;
      draw_beat_t e;
      lo = longint'($signed(rs));
      hi = longint'($signed(re));
      if (op == OP_LOAD) begin
        seed = sv;
        i = 0;
      end else if (lo >= hi) begin
        i = lo;
      end else if (re != urir_pkg::IntMax) begin
        i = floor_of(scaled_draw(lo, hi + 1));
        if (i < lo) i = lo;
        if (i > hi) i = hi;
      end else if (rs != urir_pkg::IntMin) begin
        i = floor_of(round_signed53(scaled_draw(lo - 1, hi) + to_grid(1)));
        if (i < lo) i = lo;
        if (i > hi) i = hi;
      end else begin
        x = round_signed53(scaled_draw(lo, hi) + to_grid(64'sd2147483648));
        n = x << 32;
        q = n / fix_t'(64'hFFFF_FFFF);
        sticky = (n % fix_t'(64'hFFFF_FFFF)) != 0;
        q = round53(q, sticky);
        i = floor_of(round_signed53(q + to_grid(-64'sd2147483648)));
        if (i < -64'sd2147483648) i = -64'sd2147483648;
        if (i > 64'sd2147483647) i = 64'sd2147483647;
      end
      e.value = i[31:0];
      e.seed = seed;
      awaited.push_back(e);
    endfunction

    function void check_beat(logic [31:0] v, logic [31:0] s);
      draw_beat_t e;
      beats++;
      if (awaited.size() == 0) begin
        $display("%0t: beat with nothing awaited: value %h seed %h", $time, v, s);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (v !== e.value) begin
        $display("%0t: value expected %h actual %h", $time, e.value, v);
        errors++;
      end
      if (s !== e.seed) begin
        $display("%0t: seed expected %h actual %h", $time, e.seed, s);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               op_i = 1'b0;
  logic signed [31:0] seed_value_i = '0;
  logic signed [31:0] range_start_i = '0;
  logic signed [31:0] range_end_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] value_o;
  logic signed [31:0] seed_out_o;

  draw_scoreboard sb = new();
  longint cycles = 0;
  int     loads = 0;
  int     draws = 0;
  int     full_draws = 0;
  int     burst_left = 0;

  uniform_random_in_range dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_request(op_i, seed_value_i, range_start_i, range_end_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(value_o, seed_out_o);
  end

  always @(posedge clk_i) begin
    case ((cycles / 2000) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(1, 0) == 0);
      2: out_stall_i <= ($urandom_range(9, 0) < 8);
      default: out_stall_i <= (cycles % 7) < 3;
    endcase
  end

  task automatic send(logic op, logic [31:0] sv, logic [31:0] rs, logic [31:0] re);
    if (burst_left == 0) begin
      burst_left = $urandom_range(8, 1);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i <= op;
    seed_value_i <= sv;
    range_start_i <= rs;
    range_end_i <= re;
    if (op == OP_LOAD) loads++;
    else draws++;
    if (op == OP_DRAW && rs == urir_pkg::IntMin && re == urir_pkg::IntMax) full_draws++;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic idle_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
    burst_left = 0;
  endtask

  task automatic random_request();
    logic [31:0] a;
    logic [31:0] b;
    int          kind;
    kind = $urandom_range(19, 0);
    a = $urandom;
    b = $urandom;
    case (kind)
      0, 1: begin
        send(OP_LOAD, $urandom, $urandom, $urandom);
        return;
      end
      2: b = a;
      3: b = urir_pkg::IntMax;
      4: begin
        a = urir_pkg::IntMin;
        b = urir_pkg::IntMax;
      end
      5, 6, 7, 8: b = a + $urandom_range(200, 1);
      9: a = urir_pkg::IntMin;
      10: a = urir_pkg::IntMax - $urandom_range(50, 0);
      default: if ($signed(a) > $signed(b)) {a, b} = {b, a};
    endcase
    if (kind == 10) b = urir_pkg::IntMax;
    if ((kind >= 5 && kind <= 8) && $signed(b) < $signed(a)) b = a;
    send(OP_DRAW, $urandom, a, b);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OP_DRAW, '0, -32'sd5, 32'sd5);
    send(OP_DRAW, '0, 32'sd0, 32'sd1);
    send(OP_DRAW, '1, 32'sd7, 32'sd7);
    send(OP_DRAW, '1, urir_pkg::IntMax, urir_pkg::IntMin);
    send(OP_LOAD, '0, '0, '0);
    send(OP_DRAW, '0, urir_pkg::IntMin, urir_pkg::IntMax);
    send(OP_LOAD, '1, '1, '1);
    send(OP_DRAW, '0, urir_pkg::IntMin, urir_pkg::IntMax - 1);
    send(OP_DRAW, '0, urir_pkg::IntMin, urir_pkg::IntMin + 1);
    send(OP_DRAW, '0, urir_pkg::IntMax - 1, urir_pkg::IntMax);
    send(OP_DRAW, '0, urir_pkg::IntMin + 1, urir_pkg::IntMax);
    send(OP_DRAW, '0, 32'sd0, urir_pkg::IntMax);
    send(OP_LOAD, urir_pkg::IntMin, '0, '0);
    send(OP_DRAW, '0, urir_pkg::IntMin, urir_pkg::IntMax);
    send(OP_LOAD, urir_pkg::IntMax, '0, '0);
    send(OP_DRAW, '0, urir_pkg::IntMin, urir_pkg::IntMax);
    send(OP_DRAW, '0, -32'sd1, 32'sd0);
    send(OP_DRAW, '0, urir_pkg::IntMin, -32'sd1);
    send(OP_DRAW, '0, urir_pkg::IntMax, urir_pkg::IntMax);
    send(OP_DRAW, '0, urir_pkg::IntMin, urir_pkg::IntMin);
    idle_until_drained();

    for (int n = 0; n < RandomItems; n++) begin
      random_request();
      if (n == RandomItems / 2) idle_until_drained();
    end
    idle_until_drained();
    repeat (500) @(posedge clk_i);

    $display("covered %0d draws (%0d over the full range) and %0d seed loads, %0d beats",
             draws, full_draws, loads, sb.beats);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d beats still awaited", sb.errors, sb.awaited.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
